// ===== rtl/interrupt_table_entry_parser_assert.svh =====
// ----------------------------------------------------------------------------
// interrupt_table_entry_parser_assert.svh
// Assertion macros shared by the table parser modules.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_TABLE_ENTRY_PARSER_ASSERT_SVH
`define INTERRUPT_TABLE_ENTRY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define ITEP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ITEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itep_pkg.sv =====
// ----------------------------------------------------------------------------
// itep_pkg
// Types and constants of the interrupt table entry parser.
// ----------------------------------------------------------------------------
package itep_pkg;

    // Default list capacities
    localparam int DEF_MAX_CPUS      = 64;
    localparam int DEF_MAX_OVERRIDES = 16;

    // Table layout
    localparam logic [16:0] FIRST_ENTRY = 17'd44;
    localparam logic [16:0] OFFSET_MAX  = 17'h1FFFF;
    localparam int          ENTRY_KEEP  = 12;

    // Entry type codes and minimum lengths
    localparam logic [7:0] TYPE_CPU     = 8'd0;
    localparam logic [7:0] TYPE_IOC     = 8'd1;
    localparam logic [7:0] TYPE_OVR     = 8'd2;
    localparam logic [7:0] MIN_LEN_CPU  = 8'd8;
    localparam logic [7:0] MIN_LEN_IOC  = 8'd12;
    localparam logic [7:0] MIN_LEN_OVR  = 8'd10;
    localparam logic [7:0] MIN_LEN_ANY  = 8'd2;

    // Record kinds
    localparam logic [1:0] KIND_CPU     = 2'd0;
    localparam logic [1:0] KIND_IOC     = 2'd1;
    localparam logic [1:0] KIND_OVR     = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Result queue depth (power of two, at least 2)
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [5:0]  slot;
        logic [7:0]  apic_id;
        logic        cpu_enabled;
        logic [31:0] ioc_address;
        logic [31:0] gsi;
        logic [7:0]  bus_id;
        logic [7:0]  src_irq;
        logic [15:0] irq_flags;
        logic [6:0]  cpu_total;
        logic [4:0]  override_total;
        logic        last_result;
    } t_out;

    // Results caused by one request, in order: rec0 first
    typedef struct packed {
        logic [1:0] count;
        t_out       rec0;
        t_out       rec1;
    } t_push;

endpackage

// ===== rtl/interrupt_table_entry_parser.sv =====
// Records are built combinationally and registered in the result queue.
// Throughput: one table byte per cycle while input ready is high; each byte
// yields at most two records. Output drains one record per cycle while output
// ready is high, from a 4-entry result queue; input ready drops only while
// fewer than two queue slots are free (a final byte ending an entry gives two).
// Reset: synchronous, active low; clears walk state, list counts and queue.
// ----------------------------------------------------------------------------
// interrupt_table_entry_parser
// Walks an interrupt-controller description table one byte per cycle while input
// ready is high and reports processor, I/O controller, override and summary records.
// ----------------------------------------------------------------------------
module interrupt_table_entry_parser
    import itep_pkg::*;
#(
    parameter int MAX_CPUS      = DEF_MAX_CPUS,
    parameter int MAX_OVERRIDES = DEF_MAX_OVERRIDES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_push push;
    logic  room;
    logic  accept;

    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // Byte walk and record build
    itep_walker #(
        .MAX_CPUS      (MAX_CPUS),
        .MAX_OVERRIDES (MAX_OVERRIDES)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (i_in_data),
        .o_push  (push)
    );

    // Result queue
    itep_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/itep_walker.sv =====
// ----------------------------------------------------------------------------
// itep_walker
// Per-byte table walk: header length capture, entry tracking and record build.
// ----------------------------------------------------------------------------
`include "interrupt_table_entry_parser_assert.svh"

module itep_walker
    import itep_pkg::*;
#(
    parameter int MAX_CPUS      = DEF_MAX_CPUS,
    parameter int MAX_OVERRIDES = DEF_MAX_OVERRIDES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_in   i_item,
    output t_push o_push
);

    localparam logic [8:0] CPU_CAP = 9'(MAX_CPUS);
    localparam logic [6:0] OVR_CAP = 7'(MAX_OVERRIDES);

    logic [16:0] r_byte_offset, n_byte_offset;
    logic [31:0] r_table_length, n_table_length;
    logic [16:0] r_entry_start, n_entry_start;
    logic [7:0]  r_entry_length, n_entry_length;
    logic        r_walk_stopped, n_walk_stopped;
    logic [6:0]  r_cpu_count, n_cpu_count;
    logic [4:0]  r_override_count, n_override_count;
    logic        r_ioc_taken, n_ioc_taken;
    logic [7:0]  r_eb [ENTRY_KEEP];
    logic [7:0]  n_eb [ENTRY_KEEP];

    logic [16:0] rel;
    logic [17:0] next_start;
    logic [32:0] entry_end;
    logic [31:0] ioc_addr;
    logic        emit;
    t_out        entry_rec;
    t_out        sum_rec;

    // Walk one byte
    always_comb begin
        n_byte_offset    = r_byte_offset;
        n_table_length   = r_table_length;
        n_entry_start    = r_entry_start;
        n_entry_length   = r_entry_length;
        n_walk_stopped   = r_walk_stopped;
        n_cpu_count      = r_cpu_count;
        n_override_count = r_override_count;
        n_ioc_taken      = r_ioc_taken;
        n_eb             = r_eb;
        emit             = 1'b0;
        entry_rec        = '0;
        sum_rec          = '0;
        ioc_addr         = '0;
        rel              = r_byte_offset - r_entry_start;
        next_start       = '0;
        entry_end        = 33'(r_entry_start) + 33'(i_item.data_byte);

        if (r_byte_offset < 17'd8) begin
            // header: little-endian length in bytes 4..7
            if (r_byte_offset[2]) begin
                n_table_length[{r_byte_offset[1:0], 3'b000} +: 8] =
                    r_table_length[{r_byte_offset[1:0], 3'b000} +: 8] | i_item.data_byte;
            end
            if (r_byte_offset[2:0] == 3'd7 && n_table_length < 32'(FIRST_ENTRY)) begin
                n_walk_stopped = 1'b1;
            end
        end else if (r_byte_offset != OFFSET_MAX && !r_walk_stopped &&
                     32'(r_byte_offset) < r_table_length &&
                     r_byte_offset >= r_entry_start) begin
            if (rel < 17'(ENTRY_KEEP)) begin
                n_eb[rel[3:0]] = i_item.data_byte;
            end
            // entry length byte: sanity check against minimum length and table bounds
            if (rel == 17'd1) begin
                n_entry_length = i_item.data_byte;
                if (i_item.data_byte < MIN_LEN_ANY || entry_end > 33'(r_table_length)) begin
                    n_walk_stopped = 1'b1;
                end
            end
            // last byte of the entry
            if (!n_walk_stopped && rel != '0 &&
                18'(rel) + 18'd1 == 18'(n_entry_length)) begin
                next_start = 18'(r_entry_start) + 18'(n_entry_length);
                if (n_eb[0] == TYPE_CPU && n_entry_length >= MIN_LEN_CPU) begin
                    if ({2'b00, r_cpu_count} < CPU_CAP) begin
                        emit                  = 1'b1;
                        entry_rec.record_kind = KIND_CPU;
                        entry_rec.slot        = r_cpu_count[5:0];
                        entry_rec.apic_id     = n_eb[3];
                        entry_rec.cpu_enabled = n_eb[4][0];
                        n_cpu_count           = r_cpu_count + 7'd1;
                    end
                end else if (n_eb[0] == TYPE_IOC && n_entry_length >= MIN_LEN_IOC) begin
                    if (!r_ioc_taken) begin
                        ioc_addr              = {n_eb[7], n_eb[6], n_eb[5], n_eb[4]};
                        emit                  = 1'b1;
                        entry_rec.record_kind = KIND_IOC;
                        entry_rec.ioc_address = ioc_addr;
                        entry_rec.gsi         = {n_eb[11], n_eb[10], n_eb[9], n_eb[8]};
                        n_ioc_taken           = (ioc_addr != '0);
                    end
                end else if (n_eb[0] == TYPE_OVR && n_entry_length >= MIN_LEN_OVR) begin
                    if ({2'b00, r_override_count} < OVR_CAP) begin
                        emit                  = 1'b1;
                        entry_rec.record_kind = KIND_OVR;
                        entry_rec.slot        = 6'(r_override_count);
                        entry_rec.gsi         = {n_eb[7], n_eb[6], n_eb[5], n_eb[4]};
                        entry_rec.bus_id      = n_eb[2];
                        entry_rec.src_irq     = n_eb[3];
                        entry_rec.irq_flags   = {n_eb[9], n_eb[8]};
                        n_override_count      = r_override_count + 5'd1;
                    end
                end
                if (next_start > 18'(OFFSET_MAX)) begin
                    n_walk_stopped = 1'b1;
                end else begin
                    n_entry_start = next_start[16:0];
                end
            end
        end

        if (r_byte_offset != OFFSET_MAX) begin
            n_byte_offset = r_byte_offset + 17'd1;
        end

        // end of table: summary and walk restart
        sum_rec.record_kind    = KIND_SUMMARY;
        sum_rec.cpu_total      = n_cpu_count;
        sum_rec.override_total = n_override_count;
        sum_rec.last_result    = 1'b1;
        if (i_item.final_byte) begin
            n_byte_offset  = '0;
            n_table_length = '0;
            n_entry_start  = FIRST_ENTRY;
            n_entry_length = '0;
            n_walk_stopped = 1'b0;
        end
        entry_rec.last_result = !i_item.final_byte;
    end

    // Pack results in order
    always_comb begin
        o_push = '0;
        if (i_push) begin
            o_push.count = {1'b0, emit} + {1'b0, i_item.final_byte};
            o_push.rec0  = emit ? entry_rec : sum_rec;
            o_push.rec1  = sum_rec;
        end
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset    <= '0;
            r_table_length   <= '0;
            r_entry_start    <= FIRST_ENTRY;
            r_entry_length   <= '0;
            r_walk_stopped   <= 1'b0;
            r_cpu_count      <= '0;
            r_override_count <= '0;
            r_ioc_taken      <= 1'b0;
        end else if (i_push) begin
            r_byte_offset    <= n_byte_offset;
            r_table_length   <= n_table_length;
            r_entry_start    <= n_entry_start;
            r_entry_length   <= n_entry_length;
            r_walk_stopped   <= n_walk_stopped;
            r_cpu_count      <= n_cpu_count;
            r_override_count <= n_override_count;
            r_ioc_taken      <= n_ioc_taken;
        end
    end

    // Entry byte capture, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_eb <= n_eb;
        end
    end

    `ITEP_ASSERT_IMPL(a_two_ends_in_summary, i_clk, i_rst_n, o_push.count == 2'd2, o_push.rec1.record_kind == KIND_SUMMARY && o_push.rec0.record_kind != KIND_SUMMARY, "two results must be entry then summary")
    `ITEP_ASSERT_IMPL(a_one_without_final, i_clk, i_rst_n, i_push && !i_item.final_byte, o_push.count != 2'd2 && o_push.count != 2'd3, "non-final byte gave more than one result")
    `ITEP_ASSERT_NEXT(a_final_restarts, i_clk, i_rst_n, i_push && i_item.final_byte, r_byte_offset == '0 && r_entry_start == FIRST_ENTRY && !r_walk_stopped, "walk did not restart after final byte")

endmodule

// ===== rtl/itep_out_fifo.sv =====
// ----------------------------------------------------------------------------
// itep_out_fifo
// Result queue: takes up to two records a cycle, delivers one a cycle while i_ready is high.
// ----------------------------------------------------------------------------
`include "interrupt_table_entry_parser_assert.svh"

module itep_out_fifo
    import itep_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    t_out          r_mem [OQ_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    // room for a worst-case request of two records
    assign o_room  = (r_count <= CW'(OQ_DEPTH - 2));

    // Pointer and fill updates
    always_comb begin
        n_wptr  = r_wptr + PW'(i_push.count);
        n_rptr  = r_rptr + PW'(pop);
        n_count = r_count + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Record storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wptr + PW'(1)] <= i_push.rec1;
        end
    end

    `ITEP_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(OQ_DEPTH), "queue fill above depth")
    `ITEP_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push.count != 2'd0, o_room, "records pushed without room")
    `ITEP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && i_push.count == 2'd0, r_count == $past(r_count) - CW'(1), "pop did not lower fill")

endmodule
